>>> hdl/golden_section_minimizer_core_macros.svh
// Assertion macros used by the golden-section minimizer checker.
// Self-contained; included by the checker file by bare name.
`ifndef GOLDEN_SECTION_MINIMIZER_CORE_MACROS_SVH
`define GOLDEN_SECTION_MINIMIZER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define GSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define GSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/gsm_pkg.sv
// Shared types and constants of the golden-section minimizer.
// No dependencies; imported by gsm_cfg, the core and the testbench.
package gsm_pkg;

    localparam int TOL_BITS   = 46;
    localparam int LIMIT_BITS = 16;
    localparam int PADDR_BITS = 4;
    localparam int PDATA_BITS = 64;

    localparam logic [TOL_BITS-1:0]   TOL_RESET   = 46'd168;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd1000;

    // round(2^32 / phi)
    localparam logic [31:0] INV_PHI_Q32 = 32'd2654435769;
    // half of the 2^32 product scale, for round half up
    localparam logic [63:0] ROUND_HALF  = 64'h0000_0000_8000_0000;

    // register select bit of paddr (registers sit 8 bytes apart)
    localparam logic REG_TOLERANCE  = 1'b0;
    localparam logic REG_STEP_LIMIT = 1'b1;

    typedef struct packed {
        logic [TOL_BITS-1:0]   tol;
        logic [LIMIT_BITS-1:0] limit;
    } t_cfg;

endpackage

>>> hdl/gsm_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on nothing but its ports; used by the sequencer twice per iteration.
module gsm_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    // register the product
    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

>>> hdl/gsm_cfg.sv
// APB-style register file: tolerance and step limit.
// Depends on gsm_pkg for the register layout and reset values.
module gsm_cfg
    import gsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [TOL_BITS-1:0]   r_tol;
    logic [LIMIT_BITS-1:0] r_limit;
    logic                  wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // write on the access beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol   <= TOL_RESET;
            r_limit <= LIMIT_RESET;
        end else if (wr_en) begin
            if (paddr[3] == REG_TOLERANCE) begin
                r_tol <= pwdata[TOL_BITS-1:0];
            end else begin
                r_limit <= pwdata[LIMIT_BITS-1:0];
            end
        end
    end

    // read back; misaligned addresses read zero
    always_comb begin
        prdata = '0;
        if (paddr[2:0] == 3'd0) begin
            if (paddr[3] == REG_STEP_LIMIT) begin
                prdata = PDATA_BITS'(r_limit);
            end else begin
                prdata = PDATA_BITS'(r_tol);
            end
        end
    end

    assign o_cfg.tol   = r_tol;
    assign o_cfg.limit = r_limit;

endmodule

>>> hdl/golden_section_minimizer_core.sv
// Golden-section minimizer of f(x) = (x - 3) * x, signed fixed point.
// Depends on gsm_pkg, gsm_cfg (register file) and gsm_mul (shared multiplier).
//
// Give two interval ends with start while busy is low; one result follows
// on o_valid for a single cycle and cannot be stalled, so the receiver must
// take it then. The span and the tolerance set the number of iterations, and
// the step limit caps it. Each iteration is a stop check, two passes through
// the one 32x32 multiplier (low and high halves of span/phi), a probe update
// and the objective compare. busy is high from the accept until the result
// strobe, and a new item may start in the strobe cycle.
// Write the configuration registers only while busy is low.
module golden_section_minimizer_core
    import gsm_pkg::*;
#(
    parameter int FRAC_BITS = 24,
    parameter int WORD_BITS = 47
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [WORD_BITS-1:0] i_left_end,
    input  logic signed [WORD_BITS-1:0] i_right_end,
    output logic                        o_valid,
    output logic signed [WORD_BITS-1:0] o_minimum_estimate,
    output logic [LIMIT_BITS-1:0]       o_iterations_used,
    output logic                        o_converged,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [PADDR_BITS-1:0]       paddr,
    input  logic [PDATA_BITS-1:0]       pwdata,
    output logic [PDATA_BITS-1:0]       prdata,
    output logic                        pready
);

    localparam int W  = WORD_BITS;
    localparam int SW = ((W + 1) > (FRAC_BITS + 3)) ? (W + 1) : (FRAC_BITS + 3);
    localparam logic signed [SW-1:0] THREE = SW'(3) <<< FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MLO,
        S_MHI,
        S_UPD,
        S_CMP
    } t_state;

    t_cfg cfg;

    t_state                r_state, n_state;
    logic signed [W-1:0]   r_lo, n_lo, r_hi, n_hi, r_pl, n_pl, r_pr, n_pr;
    logic [LIMIT_BITS-1:0] r_iter, n_iter;
    logic [31:0]           r_acc, n_acc;
    logic                  r_valid, n_valid;
    logic signed [W-1:0]   r_mid, n_mid;
    logic [LIMIT_BITS-1:0] r_iters, n_iters;
    logic                  r_conv, n_conv;

    logic signed [W:0]     span_diff, gap_diff, mid_sum;
    logic [63:0]           span64, mul_p, lo_round, q64;
    logic [31:0]           mul_a;
    logic [W-1:0]          q;
    logic                  small_gap, f_not_less;
    logic signed [SW-1:0]  probe_sum;

    gsm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gsm_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (INV_PHI_Q32),
        .o_p   (mul_p)
    );

    // span of the current bracket, split into multiplier halves
    assign span_diff = (W + 1)'(r_hi) - (W + 1)'(r_lo);
    assign span64    = 64'(span_diff[W-1:0]);
    assign mul_a     = (r_state == S_MHI) ? span64[63:32] : span64[31:0];

    // span/phi = hi*C + round(lo*C / 2^32)
    assign lo_round = mul_p + ROUND_HALF;
    assign q64      = mul_p + 64'(r_acc);
    assign q        = q64[W-1:0];

    // stop test on the previous probe gap
    assign gap_diff  = (W + 1)'(r_pr) - (W + 1)'(r_pl);
    assign small_gap = gap_diff[W] || (64'(gap_diff[W-1:0]) < 64'(cfg.tol));

    // exact f(pl) >= f(pr): compare pl + pr against 3
    assign probe_sum = SW'(r_pl) + SW'(r_pr);
    always_comb begin
        if (r_pl == r_pr) begin
            f_not_less = 1'b1;
        end else if (r_pl < r_pr) begin
            f_not_less = (probe_sum <= THREE);
        end else begin
            f_not_less = (probe_sum >= THREE);
        end
    end

    // floor((pl + pr) / 2)
    assign mid_sum = (W + 1)'(r_pl) + (W + 1)'(r_pr);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_pl    = r_pl;
        n_pr    = r_pr;
        n_iter  = r_iter;
        n_acc   = r_acc;
        n_valid = 1'b0;
        n_mid   = r_mid;
        n_iters = r_iters;
        n_conv  = r_conv;
        case (r_state)
            S_IDLE: begin
                // take a beat and order the ends
                if (start) begin
                    if (i_left_end > i_right_end) begin
                        n_lo = i_right_end;
                        n_hi = i_left_end;
                    end else begin
                        n_lo = i_left_end;
                        n_hi = i_right_end;
                    end
                    n_pl    = n_lo;
                    n_pr    = n_hi;
                    n_iter  = '0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_iter == cfg.limit) begin
                    n_valid = 1'b1;
                    n_mid   = mid_sum[W:1];
                    n_iters = r_iter;
                    n_conv  = 1'b0;
                    n_state = S_IDLE;
                end else if (small_gap) begin
                    n_valid = 1'b1;
                    n_mid   = mid_sum[W:1];
                    n_iters = r_iter;
                    n_conv  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_MLO;
                end
            end
            S_MLO: begin
                n_state = S_MHI;
            end
            S_MHI: begin
                // hold the rounded low-half contribution
                n_acc   = lo_round[63:32];
                n_state = S_UPD;
            end
            S_UPD: begin
                // place the probes
                n_pl    = r_hi - q;
                n_pr    = r_lo + q;
                n_state = S_CMP;
            end
            S_CMP: begin
                // keep the side with the smaller value
                if (f_not_less) begin
                    n_lo = r_pl;
                end else begin
                    n_hi = r_pr;
                end
                n_iter  = r_iter + 1'b1;
                n_state = S_CHECK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_pl    <= n_pl;
        r_pr    <= n_pr;
        r_iter  <= n_iter;
        r_acc   <= n_acc;
        r_mid   <= n_mid;
        r_iters <= n_iters;
        r_conv  <= n_conv;
    end

    assign busy               = (r_state != S_IDLE);
    assign o_valid            = r_valid;
    assign o_minimum_estimate = r_mid;
    assign o_iterations_used  = r_iters;
    assign o_converged        = r_conv;

endmodule

>>> hdl/gsm_chk.sv
// Port-level checker for the golden-section minimizer, bound to the top level.
// Depends on golden_section_minimizer_core_macros.svh for the assertion macros.
`include "golden_section_minimizer_core_macros.svh"

module gsm_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    // an accepted beat makes the core busy
    `GSM_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accept without busy")
    // the result strobe comes only once the core has released busy
    `GSM_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !busy, "result while busy")
    // busy drops only together with a result
    `GSM_ASSERT_IMP(a_busy_ends, i_clk, i_rst_n, $fell(busy), o_valid, "busy fell, no result")
    // a result lasts one cycle
    `GSM_ASSERT_NXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid, "result held too long")

endmodule

bind golden_section_minimizer_core gsm_chk u_gsm_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

>>> verif/tb.sv
// Self-checking testbench of golden_section_minimizer_core: drives interval ends and
// register writes, predicts each minimum estimate and checks every result beat.
// Depends on gsm_pkg and the core RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gsm_pkg::*;

    localparam int FIX_FRAC_BITS = 24;
    localparam int END_BITS      = 47;
    localparam int WATCHDOG_CYCLES = 10000;

    localparam logic [END_BITS-1:0] END_MIN   = 47'h4000_0000_0000;
    localparam logic [END_BITS-1:0] END_MAX   = 47'h3FFF_FFFF_FFFF;
    localparam logic [END_BITS-1:0] FIX_THREE = 47'd3 << FIX_FRAC_BITS;

    localparam logic [PADDR_BITS-1:0] ADDR_TOLERANCE  = {REG_TOLERANCE, 3'b000};
    localparam logic [PADDR_BITS-1:0] ADDR_STEP_LIMIT = {REG_STEP_LIMIT, 3'b000};

    typedef struct {
        logic signed [END_BITS-1:0] estimate;
        logic [LIMIT_BITS-1:0]      iterations;
        logic                       converged;
    } t_minimum;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic signed [END_BITS-1:0] i_left_end = '0;
    logic signed [END_BITS-1:0] i_right_end = '0;
    logic                       o_valid;
    logic signed [END_BITS-1:0] o_minimum_estimate;
    logic [LIMIT_BITS-1:0]      o_iterations_used;
    logic                       o_converged;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [PADDR_BITS-1:0]      paddr = '0;
    logic [PDATA_BITS-1:0]      pwdata = '0;
    logic [PDATA_BITS-1:0]      prdata;
    logic                       pready;

    // predictor copy of the registers
    logic [TOL_BITS-1:0]   tol_setting = TOL_RESET;
    logic [LIMIT_BITS-1:0] limit_setting = LIMIT_RESET;

    t_minimum pending_minima[$];
    int       mismatches = 0;
    int       quiet_cycles = 0;
    bit       steady_sender = 1'b0;

    golden_section_minimizer_core i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_left_end         (i_left_end),
        .i_right_end        (i_right_end),
        .o_valid            (o_valid),
        .o_minimum_estimate (o_minimum_estimate),
        .o_iterations_used  (o_iterations_used),
        .o_converged        (o_converged),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Search the interval exactly as the hardware should, in 64-bit signed positions.
    function automatic t_minimum predict_minimum(input logic signed [END_BITS-1:0] left,
                                                 input logic signed [END_BITS-1:0] right);
        longint      lo, hi, pl, pr, q, swap, tol, three, a, b;
        int          step, count;
        logic        done;
        logic [95:0] wide;
        t_minimum    r;
        lo = left;
        hi = right;
        tol = tol_setting;
        three = longint'(3) <<< FIX_FRAC_BITS;
        if (lo > hi) begin
            swap = lo;
            lo = hi;
            hi = swap;
        end
        pl = lo;
        pr = hi;
        count = limit_setting;
        done = 1'b0;
        for (step = 0; step < limit_setting; step++) begin
            // stop once the previous probe gap is under the tolerance
            if (pr < pl || pr - pl < tol) begin
                count = step;
                done = 1'b1;
                break;
            end
            // span/phi, rounded half up
            wide = hi - lo;
            wide = wide * INV_PHI_Q32 + ROUND_HALF;
            q = longint'(wide[95:32]);
            pl = hi - q;
            pr = lo + q;
            // f(pl) >= f(pr) reduces to a comparison of pl + pr against 3
            if (pl == pr || (pl < pr ? pl + pr <= three : pl + pr >= three))
                lo = pl;
            else
                hi = pr;
        end
        a = (pl <= pr) ? pl : pr;
        b = (pl <= pr) ? pr : pl;
        a = a + ((b - a) >>> 1);
        r.estimate = a[END_BITS-1:0];
        r.iterations = count[LIMIT_BITS-1:0];
        r.converged = done;
        return r;
    endfunction

    // Random end of random magnitude, sign-extended from a random width.
    function automatic logic signed [END_BITS-1:0] random_end();
        logic [63:0] raw;
        int          bits;
        raw = {$urandom, $urandom};
        bits = $urandom_range(1, END_BITS);
        raw = raw << (64 - bits);
        raw = $signed(raw) >>> (64 - bits);
        return raw[END_BITS-1:0];
    endfunction

    // Send one beat; start stays high afterwards unless the next call idles first.
    task automatic send_interval(input logic signed [END_BITS-1:0] left,
                                 input logic signed [END_BITS-1:0] right);
        if (!steady_sender && $urandom_range(99) < 19) begin
            start <= 1'b0;
            if ($urandom_range(1))
                while (busy) @(posedge i_clk);
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_left_end <= left;
        i_right_end <= right;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_minima.push_back(predict_minimum(left, right));
    endtask

    // Hold off the sender until every expected result has come back.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_minima.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [PADDR_BITS-1:0] addr,
                                  input logic [PDATA_BITS-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        case (addr)
            ADDR_TOLERANCE:  tol_setting = data[TOL_BITS-1:0];
            ADDR_STEP_LIMIT: limit_setting = data[LIMIT_BITS-1:0];
            default: ;
        endcase
    endtask

    // Reset values: minimum inside, beside and at the ends of the range.
    task automatic test_reset_defaults();
        send_interval('0, FIX_THREE);
        send_interval(FIX_THREE, '0);
        send_interval(47'd1 << FIX_FRAC_BITS, 47'd1 << FIX_FRAC_BITS);
        send_interval(END_MIN, END_MAX);
        send_interval(END_MAX, END_MIN);
        send_interval(END_MAX, END_MAX);
        send_interval(END_MIN, END_MIN);
        send_interval(47'd10 << FIX_FRAC_BITS, 47'd20 << FIX_FRAC_BITS);
        send_interval(-(47'sd20 <<< FIX_FRAC_BITS), -(47'sd10 <<< FIX_FRAC_BITS));
        send_interval(-47'sd1, '0);
    endtask

    // Zero tolerance never converges; upper pwdata bits must be dropped.
    task automatic test_zero_tolerance();
        drain_results();
        write_register(ADDR_TOLERANCE, 64'hFFFF_C000_0000_0000);
        write_register(ADDR_STEP_LIMIT, 64'd5);
        send_interval('0, FIX_THREE);
        send_interval(47'sd7, 47'sd7);
        send_interval(END_MIN, END_MAX);
    endtask

    // Zero step limit returns the midpoint of the ordered ends.
    task automatic test_zero_step_limit();
        drain_results();
        write_register(ADDR_TOLERANCE, 64'd168);
        write_register(ADDR_STEP_LIMIT, 64'hFFFF_FFFF_FFFF_0000);
        send_interval(END_MIN, END_MAX);
        send_interval(47'sd5, -47'sd9);
        send_interval(47'sd4, 47'sd4);
    endtask

    // Largest registers, then the tightest tolerances and a single step.
    task automatic test_register_extremes();
        drain_results();
        write_register(ADDR_TOLERANCE, '1);
        write_register(ADDR_STEP_LIMIT, '1);
        send_interval(END_MIN, END_MAX);
        send_interval('0, FIX_THREE);
        drain_results();
        write_register(ADDR_TOLERANCE, 64'd2);
        send_interval(END_MIN, END_MAX);
        drain_results();
        // a one-wide span never gets under a tolerance of one
        write_register(ADDR_TOLERANCE, 64'd1);
        write_register(ADDR_STEP_LIMIT, 64'd100);
        send_interval(END_MIN, END_MAX);
        send_interval('0, 47'sd1);
        drain_results();
        write_register(ADDR_TOLERANCE, 64'd168);
        write_register(ADDR_STEP_LIMIT, 64'd1);
        send_interval('0, FIX_THREE);
        send_interval(-47'sd5, 47'sd5);
    endtask

    // Random settings per phase, random ends; one phase runs with no sender gaps.
    task automatic test_random_phases();
        logic [PDATA_BITS-1:0]      tol_word, limit_word;
        logic signed [END_BITS-1:0] left, right;
        int                         phase, n;
        for (phase = 0; phase < 12; phase++) begin
            drain_results();
            case ($urandom_range(7))
                0: tol_word = {$urandom, $urandom} & ~64'h3FFF_FFFF_FFFF;
                1: tol_word = {$urandom, $urandom} | 64'h3FFF_FFFF_FFFF;
                2: tol_word = 64'($urandom_range(1, 3));
                default: tol_word = {$urandom, $urandom} >> $urandom_range(18, 63);
            endcase
            limit_word = {$urandom, $urandom};
            // a tolerance under two may spin to the limit, so keep the limit short
            if (tol_word[TOL_BITS-1:0] < 2)
                limit_word[LIMIT_BITS-1:0] = LIMIT_BITS'($urandom_range(0, 120));
            else begin
                case ($urandom_range(3))
                    0: limit_word[LIMIT_BITS-1:0] = '1;
                    1: limit_word[LIMIT_BITS-1:0] = LIMIT_BITS'($urandom_range(0, 65535));
                    default: limit_word[LIMIT_BITS-1:0] = LIMIT_BITS'($urandom_range(0, 90));
                endcase
            end
            write_register(ADDR_TOLERANCE, tol_word);
            write_register(ADDR_STEP_LIMIT, limit_word);
            steady_sender = (phase == 5);
            for (n = 0; n < 160; n++) begin
                left = random_end();
                case ($urandom_range(9))
                    0: right = left;
                    1, 2: right = left + END_BITS'($urandom_range(1, 4096));
                    default: right = random_end();
                endcase
                send_interval(left, right);
            end
        end
        steady_sender = 1'b0;
    endtask

    // Compare each result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_minimum want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_minima.size() == 0)
                report_mismatch("result beat with no item outstanding");
            else begin
                want = pending_minima.pop_front();
                if (o_minimum_estimate !== want.estimate)
                    report_mismatch($sformatf("minimum_estimate got %0d expected %0d",
                                              o_minimum_estimate, want.estimate));
                if (o_iterations_used !== want.iterations)
                    report_mismatch($sformatf("iterations_used got %0d expected %0d",
                                              o_iterations_used, want.iterations));
                if (o_converged !== want.converged)
                    report_mismatch($sformatf("converged got %0b expected %0b",
                                              o_converged, want.converged));
            end
        end
    end

    // End the run when no beat moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid === 1'b1)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_zero_tolerance();
        test_zero_step_limit();
        test_register_extremes();
        test_random_phases();
        drain_results();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/gsm_pkg.sv
hdl/gsm_mul.sv
hdl/gsm_cfg.sv
hdl/golden_section_minimizer_core.sv
hdl/gsm_chk.sv
verif/tb.sv
